FILE: sv/hpc_pkg.sv
// Shared types, constants and header decode functions for the HTTP packet classifier.
package hpc_pkg;

  localparam int unsigned MAX_FRAME_BYTES   = 2048;
  localparam int unsigned KEY_BYTES         = 4;
  localparam int unsigned MIN_PAYLOAD_BYTES = 50;

  // The byte counter saturates at MAX_FRAME_BYTES, so it must hold that value itself.
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
  // Payload offset is at most 14 + 60 + 60 bytes.
  localparam int unsigned OFF_W = 8;

  localparam int unsigned ETH_LEN        = 14;
  localparam int unsigned HDR_MIN_BYTES  = ETH_LEN + 20;
  localparam int unsigned OFS_ETHERTYPE  = 12;
  localparam int unsigned OFS_IHL        = 14;
  localparam int unsigned OFS_TOTLEN     = 16;
  localparam int unsigned OFS_PROTO      = 23;
  localparam int unsigned OFS_TCP_DOFF   = 12;
  localparam int unsigned PORT_BYTES     = 4;
  localparam int unsigned METHOD_BYTES   = 6;
  localparam int unsigned KEY_WINDOW_END = 16;
  localparam int unsigned TCP_MIN_BYTES  = 20;
  localparam int unsigned UDP_HDR_BYTES  = 8;

  localparam logic [15:0] ETHERTYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_TCP          = 8'd6;
  localparam logic [7:0]  PROTO_UDP          = 8'd17;
  localparam logic [3:0]  MIN_HDR_WORDS      = 4'd5;
  localparam logic [15:0] MONITOR_PORT_RESET = 16'd80;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT,
    VERDICT_NOT_IPV4,
    VERDICT_L4_SHORT,
    VERDICT_PORT_MISS,
    VERDICT_LENGTH,
    VERDICT_PAYLOAD_SHORT,
    VERDICT_NOT_HTTP,
    VERDICT_KEY_SHORT
  } verdict_t;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_RESPONSE,
    CLS_GET,
    CLS_POST,
    CLS_PUT,
    CLS_DELETE
  } http_class_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [15:0]      ether_kind;
    logic [3:0]       ihl;
    logic [7:0]       proto;
    logic [15:0]      total_len;
    logic [31:0]      port_pair;
    logic [3:0]       doff;
    logic [47:0]      method;
    logic [31:0]      key;
  } frame_t;

  function automatic logic [OFF_W-1:0] l4_start(input logic [3:0] ihl);
    return OFF_W'(ETH_LEN) + OFF_W'({ihl, 2'b00});
  endfunction

  function automatic logic [OFF_W-1:0] payload_offset(input logic [3:0] ihl,
                                                      input logic [7:0] proto,
                                                      input logic [3:0] doff);
    logic [OFF_W-1:0] tl;
    tl = '0;
    if (proto == PROTO_TCP) begin
      tl = OFF_W'({doff, 2'b00});
    end else if (proto == PROTO_UDP) begin
      tl = OFF_W'(UDP_HDR_BYTES);
    end
    return l4_start(ihl) + tl;
  endfunction

  function automatic http_class_t classify(input logic [47:0] method);
    http_class_t cls;
    cls = CLS_NONE;
    if (method[47:16] == "HTTP") begin
      cls = CLS_RESPONSE;
    end else if (method[47:24] == "GET") begin
      cls = CLS_GET;
    end else if (method[47:16] == "POST") begin
      cls = CLS_POST;
    end else if (method[47:24] == "PUT") begin
      cls = CLS_PUT;
    end else if (method == "DELETE") begin
      cls = CLS_DELETE;
    end
    return cls;
  endfunction

  // Bytes from the payload start to the key: the method word and its trailing space.
  function automatic logic [2:0] key_advance(input http_class_t cls);
    logic [2:0] adv;
    case (cls)
      CLS_RESPONSE, CLS_POST: adv = 3'd5;
      CLS_GET, CLS_PUT:       adv = 3'd4;
      CLS_DELETE:             adv = 3'd7;
      default:                adv = 3'd0;
    endcase
    return adv;
  endfunction

endpackage

FILE: sv/hpc_capture.sv
// Per-frame header capture: byte counter, field extraction and the end-of-frame snapshot.
module hpc_capture (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic [7:0]     data_byte,
  input  logic           last,
  output hpc_pkg::frame_t snap_r
);
  import hpc_pkg::*;

  frame_t           frm_r;
  frame_t           frm_nxt;
  logic [OFF_W-1:0] l4;
  logic [OFF_W-1:0] poff;
  logic             pay_ok;
  logic [POS_W-1:0] rel;
  http_class_t      cls;
  logic [2:0]       adv;

  always_comb begin
    frm_nxt = frm_r;
    l4      = l4_start(frm_r.ihl);
    poff    = payload_offset(frm_r.ihl, frm_r.proto, frm_r.doff);
    pay_ok  = (frm_r.ihl >= MIN_HDR_WORDS) &&
              ((frm_r.proto != PROTO_TCP) || (frm_r.doff >= MIN_HDR_WORDS));
    rel     = frm_r.pos - POS_W'(poff);
    // The class is stable from payload byte 4 on (byte 6 for DELETE), which is where key bytes can start.
    cls     = classify(frm_r.method);
    adv     = key_advance(cls);
    if (frm_r.pos < POS_W'(MAX_FRAME_BYTES)) begin
      frm_nxt.pos = frm_r.pos + POS_W'(1);
      if (frm_r.pos == POS_W'(OFS_ETHERTYPE) || frm_r.pos == POS_W'(OFS_ETHERTYPE + 1)) begin
        frm_nxt.ether_kind = {frm_r.ether_kind[7:0], data_byte};
      end
      if (frm_r.pos == POS_W'(OFS_IHL)) begin
        frm_nxt.ihl = data_byte[3:0];
      end
      if (frm_r.pos == POS_W'(OFS_TOTLEN) || frm_r.pos == POS_W'(OFS_TOTLEN + 1)) begin
        frm_nxt.total_len = {frm_r.total_len[7:0], data_byte};
      end
      if (frm_r.pos == POS_W'(OFS_PROTO)) begin
        frm_nxt.proto = data_byte;
      end
      if (frm_r.ihl >= MIN_HDR_WORDS) begin
        if (frm_r.pos >= POS_W'(l4) && frm_r.pos < POS_W'(l4) + POS_W'(PORT_BYTES)) begin
          frm_nxt.port_pair = {frm_r.port_pair[23:0], data_byte};
        end
        if (frm_r.pos == POS_W'(l4) + POS_W'(OFS_TCP_DOFF) && frm_r.proto == PROTO_TCP) begin
          frm_nxt.doff = data_byte[7:4];
        end
        if (pay_ok && frm_r.pos >= POS_W'(poff)) begin
          for (int k = 0; k < METHOD_BYTES; k++) begin
            if (rel == POS_W'(k)) begin
              frm_nxt.method[47-8*k -: 8] = frm_r.method[47-8*k -: 8] | data_byte;
            end
          end
          if (rel >= POS_W'(4) && rel < POS_W'(KEY_WINDOW_END) && cls != CLS_NONE &&
              rel >= POS_W'(adv) && rel < POS_W'(adv) + POS_W'(KEY_BYTES)) begin
            frm_nxt.key = {frm_r.key[23:0], data_byte};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_r <= '0;
    end else if (fire) begin
      frm_r <= last ? '0 : frm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last) begin
      snap_r <= frm_nxt;
    end
  end

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    frm_r.pos <= POS_W'(MAX_FRAME_BYTES))
    else $error("byte counter ran past the frame limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> frm_r.pos == '0 && frm_r.key == '0)
    else $error("frame state not cleared after the last byte");

endmodule

FILE: sv/hpc_judge.sv
// Verdict logic on the frame snapshot and the registered result word.
module hpc_judge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            snap_v,
  input  hpc_pkg::frame_t snap,
  input  logic [15:0]     monitor_port,
  input  logic            out_ready,
  output logic            out_free,
  output logic            out_valid,
  output logic [2:0]      out_verdict,
  output logic [2:0]      out_http_class,
  output logic [15:0]     out_source_port,
  output logic [15:0]     out_destination_port,
  output logic [15:0]     out_key_offset,
  output logic [31:0]     out_key_value
);
  import hpc_pkg::*;

  logic             out_valid_r;
  verdict_t         verdict_r, verdict_nxt;
  http_class_t      class_r, class_nxt;
  logic [15:0]      sport_r, sport_nxt;
  logic [15:0]      dport_r, dport_nxt;
  logic [15:0]      koff_r, koff_nxt;
  logic [31:0]      kval_r, kval_nxt;

  logic             is_tcp, is_udp, is_l4;
  logic [OFF_W-1:0] poff;
  logic [OFF_W-1:0] hdr_end;
  logic [15:0]      n16;
  logic [15:0]      pay_min;
  http_class_t      cls;

  always_comb begin
    is_tcp      = snap.proto == PROTO_TCP;
    is_udp      = snap.proto == PROTO_UDP;
    is_l4       = is_tcp || is_udp;
    poff        = payload_offset(snap.ihl, snap.proto, snap.doff);
    hdr_end     = l4_start(snap.ihl) +
                  (is_tcp ? OFF_W'(TCP_MIN_BYTES) : OFF_W'(UDP_HDR_BYTES));
    n16         = 16'(snap.pos);
    pay_min     = 16'(poff) + 16'(MIN_PAYLOAD_BYTES);
    cls         = classify(snap.method);
    verdict_nxt = VERDICT_ACCEPT;
    class_nxt   = CLS_NONE;
    sport_nxt   = '0;
    dport_nxt   = '0;
    koff_nxt    = '0;
    kval_nxt    = '0;
    if (snap.pos < POS_W'(HDR_MIN_BYTES) || snap.ether_kind != ETHERTYPE_IPV4) begin
      verdict_nxt = VERDICT_NOT_IPV4;
    end else if (snap.ihl < MIN_HDR_WORDS) begin
      verdict_nxt = is_l4 ? VERDICT_L4_SHORT : VERDICT_NOT_IPV4;
    end else if (is_l4 && 16'(hdr_end) > n16) begin
      verdict_nxt = VERDICT_L4_SHORT;
    end else if (is_tcp && snap.doff < MIN_HDR_WORDS) begin
      verdict_nxt = VERDICT_L4_SHORT;
    end else begin
      if (is_l4) begin
        sport_nxt = snap.port_pair[31:16];
        dport_nxt = snap.port_pair[15:0];
      end
      if (monitor_port != sport_nxt && monitor_port != dport_nxt) begin
        verdict_nxt = VERDICT_PORT_MISS;
      end else if (pay_min > snap.total_len) begin
        verdict_nxt = VERDICT_LENGTH;
      end else if (pay_min > n16) begin
        verdict_nxt = VERDICT_PAYLOAD_SHORT;
      end else if (cls == CLS_NONE) begin
        verdict_nxt = VERDICT_NOT_HTTP;
      end else begin
        class_nxt = cls;
        koff_nxt  = 16'(poff) + 16'(key_advance(cls));
        if (koff_nxt + 16'(KEY_BYTES) > n16) begin
          verdict_nxt = VERDICT_KEY_SHORT;
        end else begin
          kval_nxt = snap.key;
        end
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= snap_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_v) begin
      verdict_r <= verdict_nxt;
      class_r   <= class_nxt;
      sport_r   <= sport_nxt;
      dport_r   <= dport_nxt;
      koff_r    <= koff_nxt;
      kval_r    <= kval_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_verdict          = verdict_r;
  assign out_http_class       = class_r;
  assign out_source_port      = sport_r;
  assign out_destination_port = dport_r;
  assign out_key_offset       = koff_r;
  assign out_key_value        = kval_r;

  a_accept_has_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == VERDICT_ACCEPT |-> class_r != CLS_NONE)
    else $error("accepted word carries no HTTP class");

  a_key_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r != VERDICT_ACCEPT |-> kval_r == '0)
    else $error("key value present on a rejected word");

endmodule

FILE: sv/http_packet_classifier_unit.sv
// Top level of the HTTP packet classifier: input register, pipeline control and config.
//
// The in_ channel carries one frame byte per word, starting at the Ethernet
// destination address; in_frame_end marks the final byte. Only that final byte
// produces a word on the out_ channel: the verdict, HTTP class, transport ports,
// key offset and key bytes for the whole frame. Other bytes produce nothing.
// The cfg_ channel writes the monitored port; cfg_ready is always high, and the
// port should be changed only while no frame is in flight.
// Throughput is one byte per cycle while in_ready stays high, set by the header
// capture stage. From the accepted last byte to out_valid the frame passes the
// input register, capture into the frame snapshot, and the verdict register.
// A stalled out_ channel holds the verdict word; bytes keep flowing through
// capture, and in_ready drops only when a second frame end reaches the
// capture stage while both the snapshot and the output register are full.
// Synchronous reset clears the pipeline, the frame state and sets the
// monitored port to 80.
module http_packet_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [2:0]  out_http_class,
  output logic [15:0] out_source_port,
  output logic [15:0] out_destination_port,
  output logic [15:0] out_key_offset,
  output logic [31:0] out_key_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_monitor_port
);
  import hpc_pkg::*;

  logic        s1_v_r;
  logic [7:0]  byte_r;
  logic        end_r;
  logic        s2_v_r, s2_v_nxt;
  logic [15:0] monitor_port_r;
  logic        fire;
  logic        s2_free;
  logic        out_free;
  frame_t      snap;

  assign s2_free   = !s2_v_r || out_free;
  assign fire      = s1_v_r && (!end_r || s2_free);
  assign in_ready  = !s1_v_r || fire;
  assign cfg_ready = 1'b1;
  assign s2_v_nxt  = (s2_v_r && !out_free) || (fire && end_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      monitor_port_r <= MONITOR_PORT_RESET;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      s2_v_r <= s2_v_nxt;
      if (cfg_valid && cfg_ready) begin
        monitor_port_r <= cfg_monitor_port;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_frame_byte;
      end_r  <= in_frame_end;
    end
  end

  hpc_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (byte_r),
    .last      (end_r),
    .snap_r    (snap)
  );

  hpc_judge u_judge (
    .clk                  (clk),
    .rst_n                (rst_n),
    .snap_v               (s2_v_r),
    .snap                 (snap),
    .monitor_port         (monitor_port_r),
    .out_ready            (out_ready),
    .out_free             (out_free),
    .out_valid            (out_valid),
    .out_verdict          (out_verdict),
    .out_http_class       (out_http_class),
    .out_source_port      (out_source_port),
    .out_destination_port (out_destination_port),
    .out_key_offset       (out_key_offset),
    .out_key_value        (out_key_value)
  );

  a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_free |=> s2_v_r)
    else $error("frame snapshot dropped while the output was stalled");

  a_last_reaches_snap: assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_r |=> s2_v_r)
    else $error("last byte of a frame did not produce a snapshot");

endmodule
